// ===== src/spisbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave buffered transfer package
// Field widths, the command codes and the transaction structures shared by
// the core, its datapath engine and its checker.
// ----------------------------------------------------------------------------
package spisbt_pkg;

	localparam int CMD_W             = 3;
	localparam int IDX_W             = 6;
	localparam int BYTE_W            = 8;
	localparam int COUNT_W           = 7;
	localparam int DEFAULT_BUF_DEPTH = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_CS_FALL      = 3'd0,
		CMD_CS_RISE      = 3'd1,
		CMD_SCK_SAMPLE   = 3'd2,
		CMD_SCK_SHIFT    = 3'd3,
		CMD_WRITE_TX     = 3'd4,
		CMD_SET_TX_COUNT = 3'd5,
		CMD_READ_RX      = 3'd6
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic              mosi_bit;
		logic [IDX_W-1:0]  index;
		logic [BYTE_W-1:0] data;
	} item_t;

	typedef struct packed {
		logic               miso;
		logic [BYTE_W-1:0]  read_data;
		logic [COUNT_W-1:0] rx_count;
		logic               rx_done;
		logic               tx_done;
	} result_t;

endpackage

// ===== src/spi_slave_buffered_transfer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave buffered transfer core
// Event-driven SPI slave with receive and transmit byte stores. Every
// request transaction is one pin edge or one software access, and every one
// returns exactly one response transaction with the line and status levels.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+--------------------------------------------
//  request | req_valid / req_stall   | cmd, mosi_bit, index, data
//  response| rsp_valid / rsp_stall   | miso, read_data, rx_count, rx_done, tx_done
//
// A request transaction is taken into the input register, worked on there and
// its response is registered in the output register, so one transaction is
// accepted in every cycle unless a stalled response holds both registers.
// This rests on the transfer state being updated as each transaction is worked
// on and on the registered reads of the two byte stores.
// Reset clears the transfer state, the valid flags and the engine's copy of
// transmit entry zero; the byte stores themselves need no clearing pass.
// A stalled response holds the output register and the input register, and
// the request side sees req_stall only while both are occupied.
//
module spi_slave_buffered_transfer_core #(
	parameter int BUF_DEPTH = spisbt_pkg::DEFAULT_BUF_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [spisbt_pkg::CMD_W-1:0]      cmd,
	input  logic                              mosi_bit,
	input  logic [spisbt_pkg::IDX_W-1:0]      index,
	input  logic [spisbt_pkg::BYTE_W-1:0]     data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic                              miso,
	output logic [spisbt_pkg::BYTE_W-1:0]     read_data,
	output logic [spisbt_pkg::COUNT_W-1:0]    rx_count,
	output logic                              rx_done,
	output logic                              tx_done
);

	import spisbt_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);

	// Input register and handshake.
	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    proc;
	logic    load;

	// Output register.
	logic    rsp_valid_q;
	result_t result_q;
	result_t result;

	// Store ports.
	logic                rx_wr_en, tx_wr_en;
	logic [AW-1:0]       rx_wr_addr, tx_wr_addr;
	logic [BYTE_W-1:0]   rx_wr_data, tx_wr_data;
	logic [AW-1:0]       rx_rd_addr, tx_fetch_addr;
	logic [BYTE_W-1:0]   rx_ram_data, tx_ram_data;
	logic [BYTE_W-1:0]   rx_rdata, tx_fetch;
	logic                tx_rd_en;
	logic [IDX_W+AW-1:0] idx_ext;

	// Bypass of a store write made at the same edge as the read that follows it.
	logic                rx_byp_q, tx_byp_q;
	logic [BYTE_W-1:0]   rx_byp_data_q, tx_byp_data_q;

	// The output register frees up when it is empty or its response is taken.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign proc      = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;
	assign load      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= '{cmd: cmd, mosi_bit: mosi_bit, index: index, data: data};
		end
	end

	// The receive store is read as the transaction enters the input register,
	// so the byte is ready when a read command is worked on there.
	assign idx_ext    = (IDX_W+AW)'(index);
	assign rx_rd_addr = idx_ext[AW-1:0];

	spisbt_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUF_DEPTH)
	) u_rx_ram (
		.clk     (clk),
		.wr_en   (rx_wr_en),
		.wr_addr (rx_wr_addr),
		.wr_data (rx_wr_data),
		.rd_en   (load),
		.rd_addr (rx_rd_addr),
		.rd_data (rx_ram_data)
	);

	// The transmit store is always prefetching the byte after the current
	// position, so that a completed receive byte can load it at once. The
	// read follows the position whenever the input register is not held.
	assign tx_rd_en = !req_stall;

	spisbt_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUF_DEPTH)
	) u_tx_ram (
		.clk     (clk),
		.wr_en   (tx_wr_en),
		.wr_addr (tx_wr_addr),
		.wr_data (tx_wr_data),
		.rd_en   (tx_rd_en),
		.rd_addr (tx_fetch_addr),
		.rd_data (tx_ram_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_byp_q <= 1'b0;
			tx_byp_q <= 1'b0;
		end else begin
			if (load) begin
				rx_byp_q <= rx_wr_en && (rx_wr_addr == rx_rd_addr);
			end
			if (tx_rd_en) begin
				tx_byp_q <= tx_wr_en && (tx_wr_addr == tx_fetch_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rx_byp_data_q <= rx_wr_data;
		end
		if (tx_rd_en) begin
			tx_byp_data_q <= tx_wr_data;
		end
	end

	assign rx_rdata = rx_byp_q ? rx_byp_data_q : rx_ram_data;
	assign tx_fetch = tx_byp_q ? tx_byp_data_q : tx_ram_data;

	spisbt_engine #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.proc          (proc),
		.item          (item_s1),
		.rx_rdata      (rx_rdata),
		.tx_fetch      (tx_fetch),
		.result        (result),
		.rx_wr_en      (rx_wr_en),
		.rx_wr_addr    (rx_wr_addr),
		.rx_wr_data    (rx_wr_data),
		.tx_wr_en      (tx_wr_en),
		.tx_wr_addr    (tx_wr_addr),
		.tx_wr_data    (tx_wr_data),
		.tx_fetch_addr (tx_fetch_addr)
	);

	// Response register: filled when a transaction is worked on, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			result_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign miso      = result_q.miso;
	assign read_data = result_q.read_data;
	assign rx_count  = result_q.rx_count;
	assign rx_done   = result_q.rx_done;
	assign tx_done   = result_q.tx_done;

endmodule

// ===== src/spisbt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module spisbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/spisbt_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave transfer engine
// Holds the shift registers, counters and flags of a transfer and works out
// the next state and the result for the transaction in the input register.
// ----------------------------------------------------------------------------
module spisbt_engine #(
	parameter int BUF_DEPTH = spisbt_pkg::DEFAULT_BUF_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             proc,
	input  spisbt_pkg::item_t                item,
	input  logic [spisbt_pkg::BYTE_W-1:0]    rx_rdata,
	input  logic [spisbt_pkg::BYTE_W-1:0]    tx_fetch,
	output spisbt_pkg::result_t              result,
	output logic                             rx_wr_en,
	output logic [$clog2(BUF_DEPTH)-1:0]     rx_wr_addr,
	output logic [spisbt_pkg::BYTE_W-1:0]    rx_wr_data,
	output logic                             tx_wr_en,
	output logic [$clog2(BUF_DEPTH)-1:0]     tx_wr_addr,
	output logic [spisbt_pkg::BYTE_W-1:0]    tx_wr_data,
	output logic [$clog2(BUF_DEPTH)-1:0]     tx_fetch_addr
);

	import spisbt_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int CW = $clog2(BUF_DEPTH + 1);

	logic [BYTE_W-1:0] rx_shift_q, rx_shift_d;
	logic [2:0]        rx_bits_q, rx_bits_d;
	logic [CW-1:0]     rx_bytes_q, rx_bytes_d;
	logic              rx_fin_q, rx_fin_d;
	logic [BYTE_W-1:0] tx_shift_q, tx_shift_d;
	logic [AW-1:0]     tx_pos_q, tx_pos_d;
	logic [BYTE_W-1:0] tx_rem_q, tx_rem_d;
	logic              tx_fin_q, tx_fin_d;
	logic              pend_q, pend_d;
	logic              miso_q, miso_d;
	logic [BYTE_W-1:0] tx0_q, tx0_d;

	logic [IDX_W+AW-1:0] idx_ext;
	logic                idx_ok;
	logic [CW-1:0]       bytes_inc;
	logic [BYTE_W-1:0]   shift_in;
	logic [CW+6:0]       count_ext;
	logic [BYTE_W-1:0]   read_val;

	assign idx_ext   = (IDX_W+AW)'(item.index);
	assign idx_ok    = idx_ext < (IDX_W+AW)'(BUF_DEPTH);
	assign bytes_inc = rx_bytes_q + CW'(1);
	assign shift_in  = {rx_shift_q[BYTE_W-2:0], item.mosi_bit};

	always_comb begin
		rx_shift_d = rx_shift_q;
		rx_bits_d  = rx_bits_q;
		rx_bytes_d = rx_bytes_q;
		rx_fin_d   = rx_fin_q;
		tx_shift_d = tx_shift_q;
		tx_pos_d   = tx_pos_q;
		tx_rem_d   = tx_rem_q;
		tx_fin_d   = tx_fin_q;
		pend_d     = pend_q;
		miso_d     = miso_q;
		tx0_d      = tx0_q;
		rx_wr_en   = 1'b0;
		tx_wr_en   = 1'b0;
		read_val   = '0;
		if (proc) begin
			case (cmd_t'(item.cmd))
				CMD_CS_FALL: begin
					rx_shift_d = '0;
					rx_bits_d  = '0;
					rx_bytes_d = '0;
					rx_fin_d   = 1'b0;
					tx_pos_d   = '0;
					tx_fin_d   = (tx_rem_q == '0);
					pend_d     = 1'b0;
					miso_d     = tx0_q[BYTE_W-1];
					tx_shift_d = {tx0_q[BYTE_W-2:0], 1'b0};
				end
				CMD_CS_RISE: begin
					rx_fin_d = 1'b1;
				end
				CMD_SCK_SAMPLE: begin
					if (!rx_fin_q) begin
						if (rx_bits_q == 3'd7) begin
							rx_bits_d  = '0;
							rx_shift_d = '0;
							rx_wr_en   = rx_bytes_q < CW'(BUF_DEPTH);
							rx_bytes_d = bytes_inc;
							rx_fin_d   = (bytes_inc >= CW'(BUF_DEPTH));
							if (rx_fin_d || tx_rem_q == '0) begin
								tx_fin_d = 1'b1;
							end
							if (!tx_fin_d) begin
								tx_rem_d   = tx_rem_q - 8'd1;
								tx_pos_d   = tx_fetch_addr_of(tx_pos_q);
								tx_shift_d = tx_fetch;
							end
						end else begin
							rx_bits_d  = rx_bits_q + 3'd1;
							rx_shift_d = shift_in;
						end
						if (!rx_fin_d) begin
							pend_d = 1'b1;
						end
					end
				end
				CMD_SCK_SHIFT: begin
					if (pend_q) begin
						miso_d     = tx_shift_q[BYTE_W-1];
						tx_shift_d = {tx_shift_q[BYTE_W-2:0], 1'b0};
						pend_d     = 1'b0;
					end
				end
				CMD_WRITE_TX: begin
					tx_wr_en = idx_ok;
					if (idx_ok && idx_ext == '0) begin
						tx0_d = item.data;
					end
				end
				CMD_SET_TX_COUNT: begin
					tx_rem_d = item.data;
				end
				CMD_READ_RX: begin
					if (idx_ok) begin
						read_val = rx_rdata;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Position of the transmit byte that follows a given one, held at the last entry.
	function automatic logic [AW-1:0] tx_fetch_addr_of(input logic [AW-1:0] pos);
		tx_fetch_addr_of = (pos == AW'(BUF_DEPTH - 1)) ? pos : pos + AW'(1);
	endfunction

	assign rx_wr_addr    = rx_bytes_q[AW-1:0];
	assign rx_wr_data    = shift_in;
	assign tx_wr_addr    = idx_ext[AW-1:0];
	assign tx_wr_data    = item.data;
	assign tx_fetch_addr = tx_fetch_addr_of(tx_pos_d);

	assign count_ext        = (CW+7)'(rx_bytes_d);
	assign result.miso      = miso_d;
	assign result.read_data = read_val;
	assign result.rx_count  = count_ext[COUNT_W-1:0];
	assign result.rx_done   = rx_fin_d;
	assign result.tx_done   = tx_fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_shift_q <= '0;
			rx_bits_q  <= '0;
			rx_bytes_q <= '0;
			rx_fin_q   <= 1'b0;
			tx_shift_q <= '0;
			tx_pos_q   <= '0;
			tx_rem_q   <= '0;
			tx_fin_q   <= 1'b0;
			pend_q     <= 1'b0;
			miso_q     <= 1'b0;
			tx0_q      <= '0;
		end else begin
			rx_shift_q <= rx_shift_d;
			rx_bits_q  <= rx_bits_d;
			rx_bytes_q <= rx_bytes_d;
			rx_fin_q   <= rx_fin_d;
			tx_shift_q <= tx_shift_d;
			tx_pos_q   <= tx_pos_d;
			tx_rem_q   <= tx_rem_d;
			tx_fin_q   <= tx_fin_d;
			pend_q     <= pend_d;
			miso_q     <= miso_d;
			tx0_q      <= tx0_d;
		end
	end

endmodule

// ===== src/spisbt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave buffered transfer checker
// Watches the ports of the core and checks the response handshake and the
// consistency of the receive status it reports.
// ----------------------------------------------------------------------------
module spisbt_checker #(
	parameter int BUF_DEPTH = spisbt_pkg::DEFAULT_BUF_DEPTH
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             rsp_valid,
	input logic                             rsp_stall,
	input logic                             miso,
	input logic [spisbt_pkg::BYTE_W-1:0]    read_data,
	input logic [spisbt_pkg::COUNT_W-1:0]   rx_count,
	input logic                             rx_done,
	input logic                             tx_done
);

	import spisbt_pkg::*;

	// A stalled response stays offered.
	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response withdrawn while stalled");

	// A stalled response does not change.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(miso) && $stable(read_data)
			&& $stable(rx_count) && $stable(rx_done) && $stable(tx_done))
		else $error("response payload changed while stalled");

	// The receive count never passes the store depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> int'(rx_count) <= BUF_DEPTH)
		else $error("receive count beyond store depth");

	// A full receive store always reports reception finished.
	a_full_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && int'(rx_count) == BUF_DEPTH |-> rx_done)
		else $error("receive store full without reception finished");

endmodule

bind spi_slave_buffered_transfer_core spisbt_checker #(
	.BUF_DEPTH (BUF_DEPTH)
) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.miso      (miso),
	.read_data (read_data),
	.rx_count  (rx_count),
	.rx_done   (rx_done),
	.tx_done   (tx_done)
);

// ===== tb/spisbt_transfer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave buffered transfer checker
// Watches both channels of the core and keeps its own copy of the transfer
// state. It works out the line and status levels for every accepted request
// and compares each accepted response with the oldest one still waiting.
// ----------------------------------------------------------------------------
module spisbt_transfer_checker
	import spisbt_pkg::*;
#(
	parameter int BUF_DEPTH = DEFAULT_BUF_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [CMD_W-1:0]   cmd,
	input  logic               mosi_bit,
	input  logic [IDX_W-1:0]   index,
	input  logic [BYTE_W-1:0]  data,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic               miso,
	input  logic [BYTE_W-1:0]  read_data,
	input  logic [COUNT_W-1:0] rx_count,
	input  logic               rx_done,
	input  logic               tx_done,
	output int                 errors,
	output int                 pending
);

	// Receive side.
	logic [BYTE_W-1:0] rx_shreg;
	int                rx_bits;
	int                rx_total;
	logic              rx_over;
	logic [BYTE_W-1:0] rx_mem [BUF_DEPTH];

	// Transmit side.
	logic [BYTE_W-1:0] tx_mem [BUF_DEPTH];
	logic [BYTE_W-1:0] tx_shreg;
	int                tx_ptr;
	logic [BYTE_W-1:0] tx_left;
	logic              tx_over;
	logic              bit_owed;
	logic              miso_line;

	result_t           line_status_q[$];

	function automatic void drive_miso();
		miso_line = tx_shreg[BYTE_W-1];
		tx_shreg  = tx_shreg << 1;
	endfunction

	function automatic result_t apply_spi_event(input logic [CMD_W-1:0] c, input logic m,
			input logic [IDX_W-1:0] ix, input logic [BYTE_W-1:0] d);
		result_t           r;
		logic [BYTE_W-1:0] rd;
		rd = '0;
		case (c)
			CMD_CS_FALL: begin
				rx_shreg = '0;
				rx_bits  = 0;
				rx_total = 0;
				rx_over  = 1'b0;
				tx_ptr   = 0;
				tx_shreg = tx_mem[0];
				tx_over  = (tx_left == '0);
				bit_owed = 1'b0;
				drive_miso();
			end
			CMD_CS_RISE: rx_over = 1'b1;
			CMD_SCK_SAMPLE: begin
				// Samples once reception has finished are dropped.
				if (!rx_over) begin
					rx_shreg = {rx_shreg[BYTE_W-2:0], m};
					rx_bits++;
					if (rx_bits >= 8) begin
						rx_bits = 0;
						if (rx_total < BUF_DEPTH)
							rx_mem[rx_total] = rx_shreg;
						rx_shreg = '0;
						rx_total++;
						if (rx_total >= BUF_DEPTH)
							rx_over = 1'b1;
						if (rx_over || tx_left == '0)
							tx_over = 1'b1;
						if (!tx_over) begin
							tx_left--;
							if (tx_ptr + 1 < BUF_DEPTH)
								tx_ptr++;
							tx_shreg = tx_mem[tx_ptr];
						end
					end
					if (!rx_over)
						bit_owed = 1'b1;
				end
			end
			CMD_SCK_SHIFT: begin
				if (bit_owed) begin
					drive_miso();
					bit_owed = 1'b0;
				end
			end
			CMD_WRITE_TX: if (ix < BUF_DEPTH) tx_mem[ix] = d;
			CMD_SET_TX_COUNT: tx_left = d;
			CMD_READ_RX: if (ix < BUF_DEPTH) rd = rx_mem[ix];
			default: ;
		endcase
		r.miso      = miso_line;
		r.read_data = rd;
		r.rx_count  = COUNT_W'(rx_total);
		r.rx_done   = rx_over;
		r.tx_done   = tx_over;
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			rx_shreg  = '0;
			rx_bits   = 0;
			rx_total  = 0;
			rx_over   = 1'b0;
			tx_shreg  = '0;
			tx_ptr    = 0;
			tx_left   = '0;
			tx_over   = 1'b0;
			bit_owed  = 1'b0;
			miso_line = 1'b0;
			foreach (tx_mem[i])
				tx_mem[i] = '0;
			foreach (rx_mem[i])
				rx_mem[i] = '0;
			line_status_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (req_valid && !req_stall)
				line_status_q.push_back(apply_spi_event(cmd, mosi_bit, index, data));
			if (rsp_valid && !rsp_stall) begin
				if (line_status_q.size() == 0) begin
					errors++;
					$display("%0t: response with none expected, actual miso %0b data %0h",
						$time, miso, read_data);
				end else begin
					want = line_status_q.pop_front();
					check_field("miso", BYTE_W'(want.miso), BYTE_W'(miso));
					check_field("read_data", want.read_data, read_data);
					check_field("rx_count", BYTE_W'(want.rx_count), BYTE_W'(rx_count));
					check_field("rx_done", BYTE_W'(want.rx_done), BYTE_W'(rx_done));
					check_field("tx_done", BYTE_W'(want.tx_done), BYTE_W'(tx_done));
				end
			end
			pending = line_status_q.size();
		end
	end

endmodule

// ===== tb/tb_spi_slave_buffered_transfer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave buffered transfer core testbench
// Drives pin-edge and software-access transactions into the core and lets a
// checker beside it predict and compare every response. A short directed
// sequence comes first, then randomised transfers with stray events mixed in.
// ----------------------------------------------------------------------------
module tb_spi_slave_buffered_transfer_core;
	import spisbt_pkg::*;

	// The command field is three bits wide; the one code left over must be
	// ignored by the core.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	localparam int ITEMS       = 600;
	localparam int HOLD_CYCLES = 150;
	localparam int HOLD_AT     = 350;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [CMD_W-1:0]   cmd;
	logic               mosi_bit;
	logic [IDX_W-1:0]   index;
	logic [BYTE_W-1:0]  data;
	logic               rsp_valid;
	logic               rsp_stall;
	logic               miso;
	logic [BYTE_W-1:0]  read_data;
	logic [COUNT_W-1:0] rx_count;
	logic               rx_done;
	logic               tx_done;
	int                 errors;
	int                 pending;

	// Number of request transactions accepted so far.
	int n_sent;

	// A light shadow of the receive side, kept only so that the stimulus never
	// reads a receive entry that no transfer has written. Entries are always
	// written from zero upwards, so the written ones form a prefix of the store.
	int rx_high;
	int trk_bits;
	int trk_bytes;
	bit trk_fin;

	spi_slave_buffered_transfer_core u_top (.*);

	spisbt_transfer_checker u_check (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Idling on both sides is random, with a chance of seven in a hundred each time, apart
	// from one stretch of transactions during which neither side ever idles.
	function automatic bit take_break();
		return !(n_sent >= 100 && n_sent < 260) && ($urandom_range(99) < 7);
	endfunction

	// Offers one request transaction and returns once it has been accepted.
	// Everything changes at the falling edge; acceptance is looked at on the
	// rising edge, before the core's registers have moved.
	task automatic send_event(input logic [CMD_W-1:0] c, input logic m,
			input logic [IDX_W-1:0] ix, input logic [BYTE_W-1:0] d);
		while (take_break()) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		cmd       <= c;
		mosi_bit  <= m;
		index     <= ix;
		data      <= d;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		case (c)
			CMD_CS_FALL: begin
				trk_bits  = 0;
				trk_bytes = 0;
				trk_fin   = 1'b0;
			end
			CMD_CS_RISE: trk_fin = 1'b1;
			CMD_SCK_SAMPLE: begin
				if (!trk_fin) begin
					trk_bits++;
					if (trk_bits == 8) begin
						trk_bits = 0;
						trk_bytes++;
						if (trk_bytes > rx_high)
							rx_high = trk_bytes;
						if (trk_bytes >= DEFAULT_BUF_DEPTH)
							trk_fin = 1'b1;
					end
				end
			end
			default: ;
		endcase
		n_sent++;
		@(negedge clk);
	endtask

	// A pin event whose unused fields carry random values.
	task automatic pin_event(input logic [CMD_W-1:0] c);
		send_event(c, 1'($urandom_range(1)), IDX_W'($urandom_range(63)),
			BYTE_W'($urandom_range(255)));
	endtask

	task automatic read_back();
		if (rx_high > 0)
			send_event(CMD_READ_RX, 1'($urandom_range(1)),
				IDX_W'($urandom_range(rx_high - 1)), BYTE_W'($urandom_range(255)));
	endtask

	// Any command at all, including chip-select edges in the middle of a byte.
	task automatic stray_event();
		logic [CMD_W-1:0] c;
		c = CMD_W'($urandom_range(7));
		if (c == CMD_READ_RX)
			read_back();
		else
			pin_event(c);
	endtask

	// One chip-select frame: whole bytes, now and then a few loose bits, shifts
	// after shift_pct percent of samples and some clean-up, mostly after a CS rise.
	task automatic run_transfer(input int n_bytes, input bit noisy, input int shift_pct);
		int n_bits;
		n_bits = n_bytes * 8 + (($urandom_range(3) == 0) ? $urandom_range(7) : 0);
		pin_event(CMD_CS_FALL);
		if ($urandom_range(3) == 0)
			pin_event(CMD_SCK_SHIFT);
		for (int i = 0; i < n_bits; i++) begin
			if (noisy && $urandom_range(99) < 4)
				stray_event();
			pin_event(CMD_SCK_SAMPLE);
			if ($urandom_range(99) < shift_pct)
				pin_event(CMD_SCK_SHIFT);
		end
		if ($urandom_range(9) != 0)
			pin_event(CMD_CS_RISE);
		repeat ($urandom_range(2)) begin
			if ($urandom_range(1) == 0)
				pin_event(CMD_SCK_SHIFT);
			else
				pin_event(CMD_SCK_SAMPLE);
		end
		repeat ($urandom_range(3))
			read_back();
	endtask

	// Receiver: random stalls, plus one long hold-off while the sender keeps
	// offering, so that both registers of the core fill and it stalls requests.
	initial begin : receiver
		bit held_off;
		held_off  = 1'b0;
		rsp_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && n_sent >= HOLD_AT) begin
				held_off = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= take_break();
			end
		end
	end

	initial begin : stimulus
		logic [BYTE_W-1:0] first_byte;
		int                base;
		int                n_frames;
		first_byte = 8'hB2;
		n_frames   = 0;
		n_sent     = 0;
		rx_high    = 0;
		trk_bits   = 0;
		trk_bytes  = 0;
		trk_fin    = 1'b0;
		req_valid  = 1'b0;
		cmd        = CMD_CS_FALL;
		mosi_bit   = 1'b0;
		index      = '0;
		data       = '0;
		wait (arst_n);
		@(negedge clk);

		// Directed part. Transmit entries zero and one are set up before the
		// frame that loads them, and the count allows many loads.
		send_event(CMD_WRITE_TX, 1'b0, 6'd0, 8'h96);
		send_event(CMD_WRITE_TX, 1'b1, 6'd1, 8'hFF);
		send_event(CMD_WRITE_TX, 1'b0, 6'd63, 8'h00);
		send_event(CMD_SET_TX_COUNT, 1'b0, 6'd0, 8'hFF);
		// The spare command code must change nothing.
		send_event(CMD_UNUSED, 1'b1, 6'd63, 8'hFF);
		send_event(CMD_CS_FALL, 1'b0, 6'd0, 8'h00);
		// A shift with no bit waiting is ignored.
		send_event(CMD_SCK_SHIFT, 1'b0, 6'd0, 8'h00);
		// A second fall restarts the frame.
		send_event(CMD_CS_FALL, 1'b1, 6'd63, 8'hFF);
		// One whole byte; the first few samples are followed by shifts, the rest
		// are not, so the rest of that transmit byte is never shifted out.
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			send_event(CMD_SCK_SAMPLE, first_byte[i], 6'd0, 8'h00);
			if (i >= 5)
				send_event(CMD_SCK_SHIFT, 1'b0, 6'd0, 8'h00);
		end
		// A bit left pending when chip select rises is still sent, while a sample
		// after that is dropped.
		send_event(CMD_SCK_SAMPLE, 1'b1, 6'd0, 8'h00);
		send_event(CMD_CS_RISE, 1'b0, 6'd0, 8'h00);
		send_event(CMD_SCK_SHIFT, 1'b0, 6'd0, 8'h00);
		send_event(CMD_SCK_SAMPLE, 1'b1, 6'd0, 8'h00);
		send_event(CMD_READ_RX, 1'b0, 6'd0, 8'h00);
		send_event(CMD_SCK_SHIFT, 1'b1, 6'd63, 8'hFF);

		// Fill the whole transmit store so that any frame may load any entry.
		for (int i = 0; i < DEFAULT_BUF_DEPTH; i++)
			send_event(CMD_WRITE_TX, 1'($urandom_range(1)), IDX_W'(i),
				BYTE_W'($urandom_range(255)));

		// Random part: mostly well-formed frames of a few bytes with random
		// content, with store accesses in between and stray events on top. One
		// frame runs until the receive store is full.
		base = n_sent;
		while (n_sent - base < ITEMS) begin
			repeat ($urandom_range(3)) begin
				case ($urandom_range(4))
					0: send_event(CMD_WRITE_TX, 1'($urandom_range(1)),
						IDX_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
					1: send_event(CMD_SET_TX_COUNT, 1'($urandom_range(1)),
						IDX_W'($urandom_range(63)),
						BYTE_W'(($urandom_range(3) == 0) ? $urandom_range(255)
							: $urandom_range(6)));
					2: read_back();
					3: pin_event(CMD_UNUSED);
					default: stray_event();
				endcase
			end
			if (n_frames == 3) begin
				send_event(CMD_SET_TX_COUNT, 1'($urandom_range(1)),
					IDX_W'($urandom_range(63)), 8'hFF);
				run_transfer(DEFAULT_BUF_DEPTH, 1'b0, 25);
			end else if ($urandom_range(9) == 0) begin
				run_transfer($urandom_range(20, 9), 1'b1, 85);
			end else begin
				run_transfer($urandom_range(4), 1'b1, 85);
			end
			n_frames++;
		end
		req_valid <= 1'b0;

		// Let the last responses drain, then allow a few more cycles for any
		// response that should not be there.
		wait (pending == 0);
		repeat (8)
			@(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/spisbt_pkg.sv
src/spisbt_ram.sv
src/spisbt_engine.sv
src/spi_slave_buffered_transfer_core.sv
src/spisbt_checker.sv
tb/spisbt_transfer_checker.sv
tb/tb_spi_slave_buffered_transfer_core.sv
